// File: rtl/fbpb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpb_pkg
// Shared types, constants and the arithmetic helper of the pixel blend core.
// ----------------------------------------------------------------------------
package fbpb_pkg;

   localparam int MAX_SIZE_DEF = 1024;

   localparam int CANVAS_W = 11;
   localparam logic [CANVAS_W-1:0] CANVAS_RESET = 11'd1024;

   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;

   localparam int COORD_W = 16;
   localparam int COLOR_W = 32;
   localparam int PIXEL_W = 24;
   localparam int CHAN_W  = 8;
   localparam int NUM_CHAN = 3;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_READ  = 1'b1;

   localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FETCH,
      ST_STORE
   } state_type;

   // exact v / 255 for 16-bit v up to 65279, whose quotient fits 8 bits
   function automatic logic [CHAN_W-1:0] div255(input logic [15:0] v);
      logic [16:0] t;
      t = {1'b0, v} + 17'd1 + {9'd0, v[15:8]};
      return t[15:8];
   endfunction

endpackage

// File: rtl/framebuffer_pixel_blend_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framebuffer_pixel_blend_core
// Square RGB framebuffer with alpha-blended pixel writes and pixel reads.
// Read: result strobed in the cycle after the transfer; the next read is
//   taken only once busy has fallen. Write: read-modify-write of the pixel
//   memory through the memory read, product and store steps; busy stays high
//   until the store, or for a write off the canvas until the read (no store).
// Reset: clears all 4**clog2(MAX_SIZE) entries of the memory one entry per
//   cycle, with busy high; configuration writes are taken meanwhile.
// The receiver cannot stall: each result is valid for one cycle only.
// ----------------------------------------------------------------------------
module framebuffer_pixel_blend_core #(
   parameter int MAX_SIZE = fbpb_pkg::MAX_SIZE_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic                            req_operation,
   input  logic [fbpb_pkg::COORD_W-1:0]    req_x_coord,
   input  logic [fbpb_pkg::COORD_W-1:0]    req_y_coord,
   input  logic [fbpb_pkg::COLOR_W-1:0]    req_write_color,
   output logic                            rsp_strobe,
   output logic [fbpb_pkg::COLOR_W-1:0]    rsp_read_color,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [fbpb_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [fbpb_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [fbpb_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready
);

   localparam int AW = $clog2(MAX_SIZE);
   localparam int PW = 2 * AW;
   localparam logic [PW-1:0] LAST_ADDR = '1;
   localparam logic [fbpb_pkg::COORD_W-1:0] MAX_EDGE = fbpb_pkg::COORD_W'(MAX_SIZE);

   fbpb_pkg::state_type state_ff, state_in;
   logic [PW-1:0]       clr_ff, clr_in;
   logic [fbpb_pkg::CANVAS_W-1:0] canvas_ff, canvas_in;

   logic                         op_ff;
   logic                         on_canvas_ff;
   logic [PW-1:0]                addr_ff;
   logic [fbpb_pkg::COLOR_W-1:0] color_ff;

   logic                         accept;
   logic                         cfg_wr;
   logic [fbpb_pkg::COORD_W-1:0] edge_len;
   logic                         on_canvas;
   logic [PW-1:0]                req_addr;

   logic                         mem_wr_en;
   logic [PW-1:0]                mem_wr_addr;
   logic [fbpb_pkg::PIXEL_W-1:0] mem_wr_data;
   logic [fbpb_pkg::PIXEL_W-1:0] mem_rd_data;
   logic [fbpb_pkg::PIXEL_W-1:0] mix_pixel;
   logic                         mix_load;

   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite && pready;
   assign canvas_in = pwdata[fbpb_pkg::CANVAS_W-1:0];
   assign prdata = {{(fbpb_pkg::CSR_DATA_W-fbpb_pkg::CANVAS_W){1'b0}}, canvas_ff};

   assign busy   = (state_ff != fbpb_pkg::ST_IDLE);
   assign accept = start && !busy;

   assign edge_len  = ({5'd0, canvas_ff} > MAX_EDGE) ? MAX_EDGE : {5'd0, canvas_ff};
   assign on_canvas = (req_x_coord < edge_len) && (req_y_coord < edge_len);
   assign req_addr  = {req_y_coord[AW-1:0], req_x_coord[AW-1:0]};

   // next state
   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      case (state_ff)
         fbpb_pkg::ST_CLEAR: begin
            clr_in = clr_ff + PW'(1);
            if (clr_ff == LAST_ADDR) begin
               state_in = fbpb_pkg::ST_IDLE;
            end
         end
         fbpb_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = fbpb_pkg::ST_FETCH;
            end
         end
         fbpb_pkg::ST_FETCH: begin
            if (op_ff == fbpb_pkg::OP_WRITE && on_canvas_ff) begin
               state_in = fbpb_pkg::ST_STORE;
            end else begin
               state_in = fbpb_pkg::ST_IDLE;
            end
         end
         fbpb_pkg::ST_STORE: begin
            state_in = fbpb_pkg::ST_IDLE;
         end
         default: begin
            state_in = fbpb_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      mem_wr_en   = 1'b0;
      mem_wr_addr = addr_ff;
      mem_wr_data = mix_pixel;
      mix_load    = 1'b0;
      rsp_strobe  = 1'b0;
      case (state_ff)
         fbpb_pkg::ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_ff;
            mem_wr_data = '0;
         end
         fbpb_pkg::ST_FETCH: begin
            mix_load   = (op_ff == fbpb_pkg::OP_WRITE);
            rsp_strobe = (op_ff == fbpb_pkg::OP_READ);
         end
         fbpb_pkg::ST_STORE: begin
            mem_wr_en = 1'b1;
         end
         default: begin
            mem_wr_en = 1'b0;
         end
      endcase
   end

   assign rsp_read_color = on_canvas_ff ? {mem_rd_data, fbpb_pkg::ALPHA_OPAQUE} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= fbpb_pkg::ST_CLEAR;
         clr_ff    <= '0;
         canvas_ff <= fbpb_pkg::CANVAS_RESET;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         if (cfg_wr) begin
            canvas_ff <= canvas_in;
         end
      end
   end

   // hold the accepted item for the read or the read-modify-write
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff        <= req_operation;
         on_canvas_ff <= on_canvas;
         addr_ff      <= req_addr;
         color_ff     <= req_write_color;
      end
   end

   fbpb_store #(
      .ADDR_W (PW)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (accept),
      .rd_addr (req_addr),
      .rd_data (mem_rd_data)
   );

   fbpb_mix u_mix (
      .clock     (clock),
      .load      (mix_load),
      .color     (color_ff),
      .old_pixel (mem_rd_data),
      .new_pixel (mix_pixel)
   );

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("transfer taken without going busy");

   a_rsp_after_read: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept && req_operation == fbpb_pkg::OP_READ))
      else $error("result without a read transfer one cycle earlier");

   a_write_no_rsp: assert property (@(posedge clock) disable iff (reset)
      accept && req_operation == fbpb_pkg::OP_WRITE |=> !rsp_strobe)
      else $error("result strobed for a write");

   a_clear_after_reset: assert property (@(posedge clock)
      $past(reset) && !reset |-> busy && !rsp_strobe)
      else $error("not clearing after reset");

endmodule

// File: rtl/fbpb_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpb_store
// Pixel memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module fbpb_store #(
   parameter int ADDR_W = 20
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [ADDR_W-1:0]            wr_addr,
   input  logic [fbpb_pkg::PIXEL_W-1:0] wr_data,
   input  logic                         rd_en,
   input  logic [ADDR_W-1:0]            rd_addr,
   output logic [fbpb_pkg::PIXEL_W-1:0] rd_data
);

   localparam int DEPTH = 1 << ADDR_W;

   logic [fbpb_pkg::PIXEL_W-1:0] pixel_mem [DEPTH];
   logic [fbpb_pkg::PIXEL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         pixel_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= pixel_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/fbpb_mix.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpb_mix
// Per-channel alpha mix: registered products, then sum and divide by 255.
// ----------------------------------------------------------------------------
module fbpb_mix (
   input  logic                         clock,
   input  logic                         load,
   input  logic [fbpb_pkg::COLOR_W-1:0] color,
   input  logic [fbpb_pkg::PIXEL_W-1:0] old_pixel,
   output logic [fbpb_pkg::PIXEL_W-1:0] new_pixel
);

   localparam int PROD_W = 2 * fbpb_pkg::CHAN_W;

   logic [fbpb_pkg::CHAN_W-1:0] alpha;
   logic [fbpb_pkg::CHAN_W-1:0] alpha_inv;
   logic [PROD_W-1:0]           src_prod_ff [fbpb_pkg::NUM_CHAN];
   logic [PROD_W-1:0]           dst_prod_ff [fbpb_pkg::NUM_CHAN];

   assign alpha     = color[fbpb_pkg::CHAN_W-1:0];
   assign alpha_inv = fbpb_pkg::ALPHA_OPAQUE - alpha;

   for (genvar c = 0; c < fbpb_pkg::NUM_CHAN; c++) begin : g_chan
      logic [PROD_W:0] sum;

      always_ff @(posedge clock) begin
         if (load) begin
            src_prod_ff[c] <= PROD_W'(alpha)
               * PROD_W'(color[fbpb_pkg::CHAN_W*(c+1) +: fbpb_pkg::CHAN_W]);
            dst_prod_ff[c] <= PROD_W'(alpha_inv)
               * PROD_W'(old_pixel[fbpb_pkg::CHAN_W*c +: fbpb_pkg::CHAN_W]);
         end
      end

      assign sum = {1'b0, src_prod_ff[c]} + {1'b0, dst_prod_ff[c]};
      assign new_pixel[fbpb_pkg::CHAN_W*c +: fbpb_pkg::CHAN_W] =
         fbpb_pkg::div255(sum[PROD_W-1:0]);
   end

endmodule
